[rtl/mbdo_pkg.sv]
package mbdo_pkg;

    // Fixed widths of the stream fields.
    localparam int MASK_W   = 6;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;

    // Packed stream widths, padded to whole bytes.
    localparam int S_DATA_W = ((2 * MASK_W + TIME_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * MASK_W + 7) / 8) * 8;

    // Defaults.
    localparam int                  NUM_BUTTONS_DEF = 6;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 16'd50;

    // Per-button status returned to the top level.
    typedef struct packed {
        logic pressed;
        logic fire;
    } btn_status_t;

    // Per-button sample bits handed to a button cell.
    typedef struct packed {
        logic is_down;
        logic claim;
    } btn_sample_t;

endpackage

[rtl/mbdo_button.sv]
module mbdo_button (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  mbdo_pkg::btn_sample_t         sample,
    input  logic [mbdo_pkg::TIME_W-1:0]   now_ms,
    input  logic [mbdo_pkg::PERIOD_W-1:0] period,
    output mbdo_pkg::btn_status_t         status
);

    localparam logic [1:0] PH_RELEASED    = 2'd0;
    localparam logic [1:0] PH_DEB_PRESS   = 2'd1;
    localparam logic [1:0] PH_PRESSED     = 2'd2;
    localparam logic [1:0] PH_DEB_RELEASE = 2'd3;

    logic [1:0]                  phase_reg, phase_next;
    logic [mbdo_pkg::TIME_W-1:0] start_reg, start_next;
    logic                        taken_reg, taken_next;
    logic [mbdo_pkg::TIME_W-1:0] elapsed;
    logic                        held;
    logic                        taken_after;
    logic                        fire;

    // Elapsed time wraps modulo 2^32; the level must hold strictly longer than the period.
    assign elapsed = now_ms - start_reg;
    assign held    = elapsed > {{(mbdo_pkg::TIME_W - mbdo_pkg::PERIOD_W){1'b0}}, period};

    // Phase machine for one button.
    always_comb begin
        phase_next = phase_reg;
        start_next = start_reg;
        unique case (phase_reg)
            PH_RELEASED: begin
                if (sample.is_down) begin
                    phase_next = PH_DEB_PRESS;
                    start_next = now_ms;
                end
            end
            PH_DEB_PRESS: begin
                if (!sample.is_down) begin
                    phase_next = PH_RELEASED;
                end else if (held) begin
                    phase_next = PH_PRESSED;
                end
            end
            PH_PRESSED: begin
                if (!sample.is_down) begin
                    phase_next = PH_DEB_RELEASE;
                    start_next = now_ms;
                end
            end
            default: begin
                if (sample.is_down) begin
                    phase_next = PH_PRESSED;
                end else if (held) begin
                    phase_next = PH_RELEASED;
                end
            end
        endcase
    end

    // A released button clears its one-shot mark, then the claim is applied.
    assign taken_after = (phase_next == PH_RELEASED) ? 1'b0 : taken_reg;
    assign fire        = sample.claim && (phase_next == PH_PRESSED) && !taken_after;
    assign taken_next  = taken_after || fire;

    assign status.pressed = (phase_next == PH_PRESSED);
    assign status.fire    = fire;

    // Control state resets; the start time is always written before it is read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_RELEASED;
            taken_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            taken_reg <= taken_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            start_reg <= start_next;
        end
    end

endmodule

[rtl/multi_button_debouncer_oneshot_top.sv]
// Path: an input transfer passes the input register, then the result register, on its way
// to the master side.
// Throughput: one sample per cycle while m_tready keeps up; the per-button phase update is
// a single compare and subtract between the input register and the result register.
// Reset: synchronous, active low; all buttons released, one-shot marks clear, period 50 ms.
module multi_button_debouncer_oneshot_top #(
    parameter int NUM_BUTTONS = mbdo_pkg::NUM_BUTTONS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write: debounce_period_ms.
    input  logic                          cfg_we,
    input  logic [mbdo_pkg::PERIOD_W-1:0] cfg_wdata,
    // Input samples.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: raw_levels[5:0], now_ms[37:6], claim_mask[43:38], zero padding.
    input  logic [mbdo_pkg::S_DATA_W-1:0] s_tdata,
    // Results.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: pressed_mask[5:0], oneshot_mask[11:6], zero padding.
    output logic [mbdo_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int MW = mbdo_pkg::MASK_W;
    localparam int TW = mbdo_pkg::TIME_W;

    logic [mbdo_pkg::PERIOD_W-1:0] period_reg;
    logic                          s1_valid_reg;
    logic [MW-1:0]                 s1_raw_reg;
    logic [TW-1:0]                 s1_now_reg;
    logic [MW-1:0]                 s1_claim_reg;
    logic                          m_valid_reg;
    logic [MW-1:0]                 m_pressed_reg;
    logic [MW-1:0]                 m_fire_reg;
    logic                          advance;
    logic                          s1_load;
    logic                          step_en;
    logic [NUM_BUTTONS-1:0]        pressed_vec;
    logic [NUM_BUTTONS-1:0]        fire_vec;
    logic [MW-1:0]                 pressed_mask;
    logic [MW-1:0]                 fire_mask;

    // The result register moves when it is empty or being drained.
    assign advance  = !m_valid_reg || m_tready;
    assign s1_load  = advance || !s1_valid_reg;
    assign s_tready = s1_load;
    assign step_en  = advance && s1_valid_reg;

    // Debounce period register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= mbdo_pkg::PERIOD_RESET;
        end else if (cfg_we) begin
            period_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_load) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load && s_tvalid) begin
            s1_raw_reg   <= s_tdata[MW-1:0];
            s1_now_reg   <= s_tdata[MW+TW-1:MW];
            s1_claim_reg <= s_tdata[2*MW+TW-1:MW+TW];
        end
    end

    // One cell per button; buttons beyond the field width read as held down.
    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
        mbdo_pkg::btn_sample_t sample;
        mbdo_pkg::btn_status_t status;

        if (i < MW) begin : g_in
            assign sample.is_down = !s1_raw_reg[i];
            assign sample.claim   = s1_claim_reg[i];
        end else begin : g_out
            assign sample.is_down = 1'b1;
            assign sample.claim   = 1'b0;
        end

        mbdo_button u_button (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step_en (step_en),
            .sample  (sample),
            .now_ms  (s1_now_reg),
            .period  (period_reg),
            .status  (status)
        );

        assign pressed_vec[i] = status.pressed;
        assign fire_vec[i]    = status.fire;
    end

    // Map button results onto the fixed-width output fields.
    for (genvar j = 0; j < MW; j++) begin : g_mask
        if (j < NUM_BUTTONS) begin : g_used
            assign pressed_mask[j] = pressed_vec[j];
            assign fire_mask[j]    = fire_vec[j];
        end else begin : g_unused
            assign pressed_mask[j] = 1'b0;
            assign fire_mask[j]    = 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_pressed_reg <= pressed_mask;
            m_fire_reg    <= fire_mask;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(mbdo_pkg::M_DATA_W - 2 * MW){1'b0}}, m_fire_reg, m_pressed_reg};

endmodule

[sim/mbdo_checker.sv]
// Watches the sample and result streams of the button debouncer, predicts each result
// from its own copy of the per-button state, and compares in order of arrival.
module mbdo_checker
    import mbdo_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [PERIOD_W-1:0] cfg_wdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // tdata: raw_levels, now_ms, claim_mask, zero padding.
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    // tdata: pressed_mask, oneshot_mask, zero padding.
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  mismatch_count,
    output int                  pending_results
);

    typedef enum logic [1:0] {
        PH_RELEASED,
        PH_DEB_PRESS,
        PH_PRESSED,
        PH_DEB_RELEASE
    } phase_e;

    typedef struct packed {
        logic [MASK_W-1:0] oneshot;
        logic [MASK_W-1:0] pressed;
    } masks_t;

    phase_e              phase    [MASK_W];
    logic [TIME_W-1:0]   start_ms [MASK_W];
    logic                taken    [MASK_W];
    logic [PERIOD_W-1:0] period_ms;
    masks_t              expected_masks [$];
    int                  mismatches;

    // Advances every button by one sample, then serves the one-shot claims.
    function automatic masks_t debounce_sample(input logic [MASK_W-1:0] levels,
                                               input logic [TIME_W-1:0] now_ms,
                                               input logic [MASK_W-1:0] claims);
        masks_t            res;
        logic [TIME_W-1:0] elapsed;
        logic              down;
        logic              held;
        res = '0;
        for (int b = 0; b < MASK_W; b++) begin
            down    = !levels[b];
            elapsed = now_ms - start_ms[b];
            held    = elapsed > TIME_W'(period_ms);
            case (phase[b])
                PH_RELEASED: begin
                    if (down) begin
                        phase[b]    = PH_DEB_PRESS;
                        start_ms[b] = now_ms;
                    end
                end
                PH_DEB_PRESS: begin
                    if (!down) begin
                        phase[b] = PH_RELEASED;
                    end else if (held) begin
                        phase[b] = PH_PRESSED;
                    end
                end
                PH_PRESSED: begin
                    if (!down) begin
                        phase[b]    = PH_DEB_RELEASE;
                        start_ms[b] = now_ms;
                    end
                end
                default: begin
                    if (down) begin
                        phase[b] = PH_PRESSED;
                    end else if (held) begin
                        phase[b] = PH_RELEASED;
                    end
                end
            endcase
            if (phase[b] == PH_RELEASED) begin
                taken[b] = 1'b0;
            end
        end
        for (int b = 0; b < MASK_W; b++) begin
            res.pressed[b] = (phase[b] == PH_PRESSED);
            if (claims[b] && phase[b] == PH_PRESSED && !taken[b]) begin
                taken[b]       = 1'b1;
                res.oneshot[b] = 1'b1;
            end
        end
        return res;
    endfunction

    // Register writes, result checks and predictions, all sampled at the rising edge.
    always @(posedge aclk) begin
        masks_t want;
        if (!aresetn) begin
            for (int b = 0; b < MASK_W; b++) begin
                phase[b]    = PH_RELEASED;
                start_ms[b] = '0;
                taken[b]    = 1'b0;
            end
            period_ms = PERIOD_RESET;
            expected_masks.delete();
            mismatches = 0;
        end else begin
            if (cfg_we) begin
                period_ms = cfg_wdata;
            end
            // Compare a result transfer with the oldest prediction.
            if (m_tvalid && m_tready) begin
                if (expected_masks.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result transfer: pressed %h oneshot %h",
                                 m_tdata[MASK_W-1:0], m_tdata[2*MASK_W-1:MASK_W]);
                    end
                end else begin
                    want = expected_masks.pop_front();
                    if (m_tdata[MASK_W-1:0] !== want.pressed ||
                        m_tdata[2*MASK_W-1:MASK_W] !== want.oneshot) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: expected pressed %h oneshot %h, got %h %h",
                                     want.pressed, want.oneshot,
                                     m_tdata[MASK_W-1:0], m_tdata[2*MASK_W-1:MASK_W]);
                        end
                    end
                end
            end
            // Predict the result of a sample transfer.
            if (s_tvalid && s_tready) begin
                expected_masks.push_back(debounce_sample(s_tdata[MASK_W-1:0],
                                                         s_tdata[MASK_W +: TIME_W],
                                                         s_tdata[MASK_W+TIME_W +: MASK_W]));
            end
        end
        mismatch_count  <= mismatches;
        pending_results <= expected_masks.size();
    end

    initial begin
        mismatch_count  = 0;
        pending_results = 0;
    end

endmodule

[sim/tb_multi_button_debouncer_oneshot_top.sv]
module tb_multi_button_debouncer_oneshot_top;
    import mbdo_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SAMPLES_PER_SET = 140;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [PERIOD_W-1:0] cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    int                  mismatch_count;
    int                  pending_results;
    int                  cycle_count;
    int                  stall_requests;
    int                  stalls_served;
    logic [TIME_W-1:0]   sample_ms;
    logic [MASK_W-1:0]   button_levels;
    int                  period_sets [6] = '{0, 65535, 1, 12, 300, 50};

    multi_button_debouncer_oneshot_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    mbdo_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // The run is cut off if it hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_multi_button_debouncer_oneshot_top NOT OK");
            $finish;
        end
    end

    // Result side: short and longer random stalls, short and long ready runs, and a long hold-off on request.
    initial begin
        int r;
        m_tready = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            r = $urandom_range(0, 99);
            if (stall_requests != stalls_served) begin
                stalls_served++;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else if (r < 55) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end else if (r < 62) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(60, 120)) @(posedge aclk);
            end else if (r < 96) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(15, 60)) @(posedge aclk);
            end
        end
    end

    // Offers one sample after an optional gap and waits for its transfer.
    task automatic send_sample(input logic [MASK_W-1:0] levels,
                               input logic [TIME_W-1:0] now_ms,
                               input logic [MASK_W-1:0] claims,
                               input int                gap);
        logic [S_DATA_W-1:0] word;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        word[MASK_W-1:0]                = levels;
        word[MASK_W +: TIME_W]          = now_ms;
        word[MASK_W+TIME_W +: MASK_W]   = claims;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stops offering samples until every predicted result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_period(input int value);
        cfg_we    <= 1'b1;
        cfg_wdata <= PERIOD_W'(value);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Hand-picked samples at the reset period of 50 ms.
    task automatic run_directed();
        // Press all, wait out the exact boundary, then fire all one-shots once.
        send_sample(6'h3F, 32'd0,  6'h3F, 0);
        send_sample(6'h00, 32'd10, 6'h3F, 0);
        send_sample(6'h00, 32'd60, 6'h3F, 0);
        send_sample(6'h00, 32'd61, 6'h3F, 0);
        send_sample(6'h00, 32'd62, 6'h3F, 0);
        // A release that bounces back keeps the one-shot taken.
        send_sample(6'h15, 32'd100, 6'h00, 0);
        send_sample(6'h00, 32'd120, 6'h3F, 0);
        send_sample(6'h15, 32'd130, 6'h00, 0);
        send_sample(6'h15, 32'd181, 6'h3F, 0);
        // A press that bounces back falls to released.
        send_sample(6'h2A, 32'd200, 6'h00, 0);
        send_sample(6'h3F, 32'd220, 6'h00, 0);
        // Debounce across the wrap of the millisecond time.
        send_sample(6'h3F, 32'hFFFF_FFF0, 6'h00, 0);
        send_sample(6'h00, 32'hFFFF_FFF8, 6'h00, 0);
        send_sample(6'h00, 32'h0000_0010, 6'h3F, 0);
        send_sample(6'h00, 32'h0000_002B, 6'h3F, 0);
        send_sample(6'h3F, 32'h0000_0040, 6'h00, 0);
        send_sample(6'h3F, 32'h0000_0073, 6'h3F, 0);
        send_sample(6'h00, 32'hFFFF_FFFF, 6'h3F, 0);
        send_sample(6'h00, 32'h0000_0032, 6'h3F, 0);
        sample_ms     = 32'h0000_0032;
        button_levels = 6'h00;
    endtask

    // Buttons that change rarely and bounce now and then, with time steps around the period and jumps near the wrap.
    task automatic run_random_samples(input int period, input int count);
        logic [MASK_W-1:0] raw;
        logic [MASK_W-1:0] claims;
        int                r;
        int                gap;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 19);
            if (r < 7) begin
                sample_ms += $urandom_range(0, period / 2);
            end else if (r < 13) begin
                sample_ms += (period == 0) ? $urandom_range(0, 2)
                                           : $urandom_range(period - 1, period + 2);
            end else if (r < 18) begin
                sample_ms += $urandom_range(period + 1, 2 * period + 10);
            end else if (r == 18) begin
                sample_ms = $urandom;
            end else begin
                sample_ms = 32'hFFFF_FFFF - $urandom_range(0, period + 4);
            end
            for (int b = 0; b < MASK_W; b++) begin
                if ($urandom_range(0, 5) == 0) begin
                    button_levels[b] = ~button_levels[b];
                end
            end
            raw = button_levels;
            for (int b = 0; b < MASK_W; b++) begin
                if ($urandom_range(0, 11) == 0) begin
                    raw[b] = ~raw[b];
                end
            end
            claims = ($urandom_range(0, 3) == 0) ? '0 : MASK_W'($urandom);
            r = $urandom_range(0, 99);
            if (n < 30 || r < 70) begin
                gap = 0;
            end else if (r < 93) begin
                gap = $urandom_range(1, 3);
            end else begin
                gap = $urandom_range(10, 40);
            end
            send_sample(raw, sample_ms, claims, gap);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cycle_count    = 0;
        stall_requests = 0;
        stalls_served  = 0;
        sample_ms      = '0;
        button_levels  = '1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (int k = 0; k < 6; k++) begin
            drain_results();
            write_period(period_sets[k]);
            if (k == 2) begin
                stall_requests++;
            end
            run_random_samples(period_sets[k], SAMPLES_PER_SET);
        end
        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("tb_multi_button_debouncer_oneshot_top OK");
        end else begin
            $display("tb_multi_button_debouncer_oneshot_top NOT OK");
        end
        $finish;
    end

endmodule
